@@ rtl/core/ffp_pkg.sv @@
// Package for the fixed-point FFT unit: payload structs, controller/datapath
// command struct, twiddle sine entry function (scaled by 100).
// No dependencies.
`timescale 1ns / 1ps
package ffp_pkg;

   typedef struct packed {
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] bin_re;
      logic signed [15:0] bin_im;
      logic [5:0]         bin_index;
      logic               last_bin;
   } rsp_item_type;

   localparam int TW_SCALE = 100;

   // trunc(100*sin(step*i)) for 0 <= i <= q, q a quarter period; elaboration only
   function automatic logic [6:0] sin_entry(input int i, input int q, input real step);
      real x;
      int  v;
      x = 100.0 * $sin(step * i);
      v = int'($floor(x + 1.0e-9));
      if (i == 0) v = 0;
      if (i >= q) v = TW_SCALE;
      if (v > TW_SCALE) v = TW_SCALE;
      return v[6:0];
   endfunction

   // datapath commands from the controller
   typedef struct packed {
      logic load;      // write incoming sample at load address
      logic rd;        // read butterfly pair
      logic bf_wr;     // write butterfly results
      logic out_rd;    // read one output entry
   } dp_cmd_type;

endpackage

@@ rtl/core/ffp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ffp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ rtl/core/ffp_datapath.sv @@
// Datapath: two copies of the complex sample RAM (one per read port, writes go
// to both), twiddle multiply, output path. Uses ffp_pkg, ffp_ram.
`timescale 1ns / 1ps
module ffp_datapath
   import ffp_pkg::*;
#(
   parameter int POINTS = 64,
   localparam int AW = $clog2(POINTS)
) (
   input  logic         clock,
   input  dp_cmd_type   cmd,
   input  logic [AW-1:0] addr_p,
   input  logic [AW-1:0] addr_q,
   input  logic [AW-1:0] wr_p,
   input  logic [AW-1:0] wr_q,
   input  logic [AW-1:0] tw_idx,
   input  logic [AW-1:0] out_k,
   input  logic [AW-1:0] out_idx,
   input  logic         out_last,
   input  req_item_type req_item,
   output rsp_item_type rsp_item
);
   localparam int QTR = POINTS / 4;
   localparam int HALF = POINTS / 2;
   localparam real TW_STEP = 2.0 * 3.14159265358979323846 / POINTS;

   // Two copies of the buffer (one per read port); writes go to both.
   // Sequence: read phase A reads p and q; phase B writes p; phase C writes q.
   logic [31:0] ra_d, rb_d, w_data;
   logic [AW-1:0] w_addr, ra_addr;
   logic w_en;

   logic signed [15:0] top_re_ff, top_im_ff, bot_re_ff, bot_im_ff;
   logic signed [15:0] top_re_in, top_im_in, bot_re_in, bot_im_in;

   always_comb begin
      w_en   = cmd.load | cmd.bf_wr;
      w_addr = cmd.load ? addr_p : (cmd.rd ? wr_q : wr_p);
      w_data = cmd.load ? {req_item.sample_re, req_item.sample_im}
             : (cmd.rd ? {bot_re_ff, bot_im_ff} : {top_re_ff, top_im_ff});
      ra_addr = cmd.out_rd ? out_k : addr_p;
   end

   ffp_ram #(.WIDTH(32), .DEPTH(POINTS)) u_ram_a (
      .clock, .wr_en(w_en), .wr_addr(w_addr), .wr_data(w_data),
      .rd_addr(ra_addr), .rd_data(ra_d));
   ffp_ram #(.WIDTH(32), .DEPTH(POINTS)) u_ram_b (
      .clock, .wr_en(w_en), .wr_addr(w_addr), .wr_data(w_data),
      .rd_addr(addr_q), .rd_data(rb_d));

   // quarter-wave sine table, fixed at elaboration
   logic [6:0] sin_tab [QTR+1];
   for (genvar g = 0; g <= QTR; g++) begin : g_sin_tab
      assign sin_tab[g] = sin_entry(g, QTR, TW_STEP);
   end

   // twiddle lookup, registered with read
   logic signed [7:0] c_ff, s_ff, c_in, s_in;
   function automatic logic signed [7:0] tsin(input logic [AW-1:0] n);
      logic [AW-1:0] k;
      logic neg;
      neg = n[AW-1];
      k = {1'b0, n[AW-2:0]};
      if (k > AW'(QTR)) k = AW'(HALF) - k;
      tsin = neg ? -$signed({1'b0, sin_tab[k[AW-2:0]]})
                 :  $signed({1'b0, sin_tab[k[AW-2:0]]});
   endfunction
   always_comb begin
      s_in = tsin(tw_idx);
      c_in = tsin(tw_idx + AW'(QTR));
   end

   // stage 1: sum and difference
   logic signed [16:0] dr_ff, di_ff;
   // stage 2: products
   logic signed [24:0] p_rc_ff, p_is_ff, p_rs_ff, p_ic_ff;
   always_ff @(posedge clock) begin
      c_ff <= c_in;
      s_ff <= s_in;
      top_re_ff <= top_re_in;
      top_im_ff <= top_im_in;
      bot_re_ff <= bot_re_in;
      bot_im_ff <= bot_im_in;
   end

   // Butterfly over five controller phases:
   // 0: addresses presented; 1: data ready -> dr/di, sums;
   // 2: products, top written; 3: quotients -> bot regs; 4: bottom written.
   logic signed [7:0] c2_ff, s2_ff;
   always_ff @(posedge clock) begin
      dr_ff <= 17'($signed(ra_d[31:16])) - 17'($signed(rb_d[31:16]));
      di_ff <= 17'($signed(ra_d[15:0]))  - 17'($signed(rb_d[15:0]));
      c2_ff <= c_ff;
      s2_ff <= s_ff;
      p_rc_ff <= dr_ff * c2_ff;
      p_is_ff <= di_ff * s2_ff;
      p_rs_ff <= -(dr_ff * s2_ff);
      p_ic_ff <= di_ff * c2_ff;
   end

   // divide by 100 truncating toward zero (constant divisor)
   function automatic logic signed [24:0] div100(input logic signed [24:0] v);
      logic [24:0] a;
      logic [49:0] m;
      logic [24:0] qq;
      a = v[24] ? 25'(-v) : v;
      m = 50'(a) * 50'd335545;   // ceil(2^25/100)
      qq = m[49:25];
      if (25'(qq * 25'd100) > a) qq = qq - 25'd1;
      div100 = v[24] ? -$signed(qq) : $signed(qq);
   endfunction

   always_comb begin
      top_re_in = top_re_ff;
      top_im_in = top_im_ff;
      bot_re_in = 16'(div100(p_rc_ff) + div100(p_is_ff));
      bot_im_in = 16'(div100(p_rs_ff) + div100(p_ic_ff));
      if (cmd.rd) begin
         top_re_in = 16'($signed(ra_d[31:16]) + $signed(rb_d[31:16]));
         top_im_in = 16'($signed(ra_d[15:0]) + $signed(rb_d[15:0]));
      end
   end

   // output register
   always_ff @(posedge clock) begin
      rsp_item.bin_re    <= $signed(ra_d[31:16]);
      rsp_item.bin_im    <= $signed(ra_d[15:0]);
      rsp_item.bin_index <= 6'(out_idx);
      rsp_item.last_bin  <= out_last;
   end
endmodule

@@ rtl/core/ffp_ctrl.sv @@
// Controller: load count, butterfly sequencer, output sequencer.
// Uses ffp_pkg.
`timescale 1ns / 1ps
module ffp_ctrl
   import ffp_pkg::*;
#(
   parameter int POINTS = 64,
   localparam int AW = $clog2(POINTS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   output dp_cmd_type    cmd,
   output logic [AW-1:0] addr_p,
   output logic [AW-1:0] addr_q,
   output logic [AW-1:0] wr_p,
   output logic [AW-1:0] wr_q,
   output logic [AW-1:0] tw_idx,
   output logic [AW-1:0] out_k,
   output logic [AW-1:0] out_idx,
   output logic          out_last
);
   localparam int BF_LAST = POINTS / 2 - 1;

   typedef enum logic [3:0] {
      S_LOAD = 4'b0001, S_BF = 4'b0010, S_OUT = 4'b0100, S_DRAIN = 4'b1000
   } state_type;

   // Each butterfly runs through read, sums, product, quotient, write q
   // (top written in phase 2 via w path with rd low).
   state_type state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;          // load count / butterfly index / bin
   logic [$clog2(AW+1)-1:0] stage_ff, stage_in;
   logic [2:0] ph_ff, ph_in;
   logic [AW-1:0] p_ff, q_ff;
   logic vld_ff;

   // butterfly address generation for index cnt at stage (span = POINTS>>stage)
   logic [AW-1:0] half, j, p, q, rev;
   always_comb begin
      half = AW'(POINTS >> (stage_ff + 1));
      j = cnt_ff & (half - AW'(1));
      p = ((cnt_ff & ~(half - AW'(1))) << 1) | j;
      q = p | half;
      for (int b = 0; b < AW; b++) rev[b] = cnt_ff[AW-1-b];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      stage_in = stage_ff;
      ph_in = ph_ff;
      cmd = '0;
      addr_p = cnt_ff;
      addr_q = q;
      tw_idx = j << stage_ff;
      out_k = rev;
      wr_p = p_ff;
      wr_q = q_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in = cnt_ff + AW'(1);
               if (cnt_ff == AW'(POINTS - 1)) begin
                  state_in = S_BF;
                  stage_in = '0;
                  ph_in = '0;
               end
            end
         end
         S_BF: begin
            addr_p = p;
            ph_in = ph_ff + 3'd1;
            unique case (ph_ff)
               3'd0: ;
               3'd1: cmd.rd = 1'b1;          // sums latched
               3'd2: cmd.bf_wr = 1'b1;       // write top at p
               3'd3: ;
               3'd4: begin
                  cmd.bf_wr = 1'b1;
                  cmd.rd = 1'b1;             // select bottom write at q
                  ph_in = '0;
                  cnt_in = cnt_ff + AW'(1);
                  if (cnt_ff == AW'(BF_LAST)) begin
                     // next stage starts again at butterfly zero
                     cnt_in = '0;
                     stage_in = stage_ff + 1'b1;
                     if (stage_ff == ($clog2(AW+1))'(AW - 1)) state_in = S_OUT;
                  end
               end
               default: ph_in = '0;
            endcase
            // cmd.rd is raised in phase 1 for the top sums and in phase 4 to select the bottom write
         end
         S_OUT: begin
            cmd.out_rd = 1'b1;
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == AW'(POINTS - 1)) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_LOAD;
         default: state_in = S_LOAD;
      endcase
   end

   // out_last aligned with the output register (RAM read register, then output register)
   logic last_ff, rd_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff <= '0;
         stage_ff <= '0;
         ph_ff <= '0;
         rd_d_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         stage_ff <= stage_in;
         ph_ff <= ph_in;
         rd_d_ff <= cmd.out_rd;
         vld_ff <= rd_d_ff;
      end
      if (state_ff == S_BF && ph_ff == 3'd0) begin
         p_ff <= p;
         q_ff <= q;
      end
      last_ff <= (state_ff == S_OUT) && (cnt_ff == AW'(POINTS - 1));
   end

   // out_k of the RAM read is registered into the item together with ra data,
   // so bin index is held back through k_d_ff to stay in step with it
   logic [AW-1:0] k_d_ff;
   always_ff @(posedge clock) k_d_ff <= cnt_ff;

   assign busy = (state_ff != S_LOAD);
   assign rsp_valid = vld_ff;
   assign out_last = last_ff;
   // bin index fed to output reg is the delayed count
   assign out_idx = k_d_ff;
endmodule

@@ rtl/core/fixed_point_fft_64_unit.sv @@
// Fixed-point 64-point radix-2 DIF FFT unit.
// Load: one sample per cycle while busy is low (64 items per frame).
// After the last sample busy stays high for 192 butterflies, 64 output reads and
// one drain state. The first bin follows the last butterfly through the RAM read
// register and the output register, then one bin per cycle, strobed by rsp_valid;
// the receiver cannot stall. Sync reset returns to loading, count zero.
`timescale 1ns / 1ps
module fixed_point_fft_64_unit
   import ffp_pkg::*;
#(
   parameter int POINTS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);
   localparam int AW = $clog2(POINTS);
   dp_cmd_type cmd;
   logic [AW-1:0] addr_p, addr_q, wr_p, wr_q, tw_idx, out_k, out_idx;
   logic out_last;

   ffp_ctrl #(.POINTS(POINTS)) u_ctrl (
      .clock, .reset, .start, .busy, .rsp_valid, .cmd,
      .addr_p, .addr_q, .wr_p, .wr_q, .tw_idx, .out_k, .out_idx, .out_last);

   ffp_datapath #(.POINTS(POINTS)) u_dp (
      .clock, .cmd, .addr_p, .addr_q, .wr_p, .wr_q, .tw_idx,
      .out_k, .out_idx, .out_last, .req_item, .rsp_item);
endmodule
